// ----- hdl/lspg_pkg.sv -----
// ----------------------------------------------------------------------------
// lspg_pkg
// Shared constants, tables, types and helpers of the LED strip pattern
// generator.
// ----------------------------------------------------------------------------
package lspg_pkg;

  // Strip geometry
  localparam int STRIP_LEN  = 144;
  localparam int DOT_COUNT  = 8;
  localparam int POS_W      = $clog2(STRIP_LEN);
  localparam int IDX_W      = 8;
  localparam int CMP_W      = ((POS_W > IDX_W) ? POS_W : IDX_W) + 1;
  localparam int QUARTER    = STRIP_LEN / 4;
  localparam int THIRD      = STRIP_LEN / 3;
  localparam int TWO_THIRDS = (2 * STRIP_LEN) / 3;

  // Configuration port
  localparam int CFG_W   = 3;
  localparam int CFG_A_W = 2;
  localparam logic [CFG_A_W-1:0] CFG_MOTION_MODE      = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_COLOR_INDEX      = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_BRIGHTNESS_LEVEL = 2'd2;

  // Animation modes; any other code shows the solid colour
  localparam logic [2:0] MODE_DOTS     = 3'd0;
  localparam logic [2:0] MODE_BLINK    = 3'd1;
  localparam logic [2:0] MODE_WAVE     = 3'd2;
  localparam logic [2:0] MODE_PINGPONG = 3'd3;
  localparam logic [2:0] MODE_FLOW     = 3'd4;

  // Beat kinds
  localparam logic ACT_PIXEL   = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  // Random blink generator
  localparam logic [31:0] LFSR_SEED = 32'h1234_5678;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

  // Colour tables
  localparam logic [23:0] BASE_PALETTE [5] = '{
    24'h200000, 24'h002000, 24'h000020, 24'h202000, 24'h201010
  };
  localparam logic [23:0] DOT_PALETTE [8] = '{
    24'h200000, 24'h201000, 24'h202000, 24'h002000,
    24'h002020, 24'h000020, 24'h100010, 24'h200010
  };
  localparam logic [7:0] LEVEL_TABLE [5] = '{
    8'd30, 8'd60, 8'd100, 8'd150, 8'd255
  };

  // Position state of all modes
  typedef struct packed {
    logic [POS_W-1:0] dot_offset;
    logic [POS_W-1:0] wave_centre;
    logic [POS_W-1:0] bounce_position;
    logic             bounce_forward;
    logic [POS_W-1:0] flow_position;
    logic [31:0]      random_shift;
  } lspg_state_t;

  // Table indexes above four saturate
  function automatic logic [2:0] sat4(input logic [2:0] v);
    return (v > 3'd4) ? 3'd4 : v;
  endfunction

  // Step one LED along the strip, wrapping at the end
  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] p);
    return (p == POS_W'(STRIP_LEN - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

// ----- hdl/lspg_if.sv -----
// ----------------------------------------------------------------------------
// lspg request and response channels
// Valid/ready stream interfaces carrying request and pixel response beats.
// ----------------------------------------------------------------------------
interface lspg_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] led_index;

  modport source (output valid, action, led_index, input ready);
  modport sink   (input valid, action, led_index, output ready);
endinterface

interface lspg_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_color;
  logic [7:0]  strip_brightness;

  modport source (output valid, pixel_color, strip_brightness, input ready);
  modport sink   (input valid, pixel_color, strip_brightness, output ready);
endinterface

// ----- hdl/lspg_pixel.sv -----
// ----------------------------------------------------------------------------
// lspg_pixel
// Colour of one LED in the current frame for the selected animation mode.
// ----------------------------------------------------------------------------
module lspg_pixel
  import lspg_pkg::*;
(
  input  logic [2:0]       motion_mode,
  input  logic [2:0]       color_index,
  input  lspg_state_t      state,
  input  logic [IDX_W-1:0] led_index,
  output logic [23:0]      pixel_color
);

  logic [2:0]       c;
  logic [2:0]       c_plus1;
  logic [2:0]       c_plus2;
  logic [23:0]      base;
  logic [CMP_W-1:0] i;
  logic [CMP_W-1:0] dot_sum;
  logic [CMP_W-1:0] dot_dist;
  logic [CMP_W-1:0] wave_pos;
  logic [CMP_W-1:0] wave_dist;
  logic [CMP_W-1:0] flow_sum;
  logic [CMP_W-1:0] flow_p;

  // Palette selection, neighbours wrap modulo five
  assign c       = sat4(color_index);
  assign c_plus1 = (c == 3'd4) ? 3'd0 : c + 3'd1;
  assign c_plus2 = (c >= 3'd3) ? c - 3'd3 : c + 3'd2;
  assign base    = BASE_PALETTE[c];
  assign i       = CMP_W'(led_index);

  // Distance behind the first dot
  assign dot_sum  = i + CMP_W'(STRIP_LEN) - CMP_W'(state.dot_offset);
  assign dot_dist = (dot_sum >= CMP_W'(STRIP_LEN)) ? dot_sum - CMP_W'(STRIP_LEN) : dot_sum;

  // Distance from the wave centre
  assign wave_pos  = CMP_W'(state.wave_centre);
  assign wave_dist = (wave_pos > i) ? wave_pos - i : i - wave_pos;

  // Flow phase
  assign flow_sum = i + CMP_W'(state.flow_position);
  assign flow_p   = (flow_sum >= CMP_W'(STRIP_LEN)) ? flow_sum - CMP_W'(STRIP_LEN) : flow_sum;

  // Mode select
  always_comb begin
    pixel_color = base;
    if (i >= CMP_W'(STRIP_LEN)) begin
      pixel_color = '0;
    end else begin
      unique case (motion_mode)
        MODE_DOTS: begin
          if (dot_dist < CMP_W'(DOT_COUNT)) pixel_color = DOT_PALETTE[dot_dist[2:0]];
        end
        MODE_BLINK: begin
          pixel_color = state.random_shift[0] ? base : '0;
        end
        MODE_WAVE: begin
          pixel_color = (wave_dist < CMP_W'(QUARTER)) ? base : '0;
        end
        MODE_PINGPONG: begin
          pixel_color = (i == CMP_W'(state.bounce_position)) ? base : '0;
        end
        MODE_FLOW: begin
          if (flow_p < CMP_W'(THIRD))           pixel_color = base;
          else if (flow_p < CMP_W'(TWO_THIRDS)) pixel_color = BASE_PALETTE[c_plus1];
          else                                  pixel_color = BASE_PALETTE[c_plus2];
        end
        default: begin
          pixel_color = base;
        end
      endcase
    end
  end

endmodule

// ----- hdl/led_strip_pattern_generator.sv -----
// ----------------------------------------------------------------------------
// led_strip_pattern_generator
// Per-LED colour generator for a 1-D strip with several animation modes.
// ----------------------------------------------------------------------------
// Takes one request beat per clock unless a pixel request waits on a stalled
// response. A pixel request gives one registered response beat (colour and
// brightness); a frame-advance request gives none and moves the active mode's
// position on the cycle it leaves the input register. The input register
// feeds the colour logic and the output register directly, so request ready
// follows response ready in the same cycle once both registers hold pixels.
// Configuration writes are to be made only with no request in flight.
module led_strip_pattern_generator
  import lspg_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  lspg_req_if.sink           req,
  lspg_rsp_if.source         rsp,
  input  logic               wr_en,
  input  logic [CFG_A_W-1:0] wr_index,
  input  logic [CFG_W-1:0]   wr_data
);

  logic [2:0]       motion_mode;
  logic [2:0]       color_index;
  logic [2:0]       brightness_level;

  lspg_state_t      state;
  lspg_state_t      state_next;

  logic             s1_valid;
  logic             s1_action;
  logic [IDX_W-1:0] s1_led_index;
  logic             s1_go;
  logic             out_free;

  logic [23:0]      color;
  logic [POS_W-1:0] bounce_step;
  logic             in_strip;

  logic             rsp_valid;
  logic [23:0]      rsp_color;
  logic [7:0]       rsp_bright;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      motion_mode      <= '0;
      color_index      <= '0;
      brightness_level <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_MOTION_MODE:      motion_mode      <= wr_data;
        CFG_COLOR_INDEX:      color_index      <= wr_data;
        CFG_BRIGHTNESS_LEVEL: brightness_level <= wr_data;
        default: ;
      endcase
    end
  end

  // Handshake: advance beats drain without needing the output register
  assign out_free  = !rsp_valid || rsp.ready;
  assign s1_go     = s1_valid && (s1_action == ACT_ADVANCE || out_free);
  assign req.ready = !s1_valid || s1_go;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s1_action    <= req.action;
      s1_led_index <= req.led_index;
    end
  end

  // Colour of the held request
  lspg_pixel u_pixel (
    .motion_mode (motion_mode),
    .color_index (color_index),
    .state       (state),
    .led_index   (s1_led_index),
    .pixel_color (color)
  );

  assign in_strip = CMP_W'(s1_led_index) < CMP_W'(STRIP_LEN);

  // Ping-pong step, clamped at both ends
  always_comb begin
    if (state.bounce_forward) begin
      bounce_step = (state.bounce_position == POS_W'(STRIP_LEN - 1))
                  ? POS_W'(STRIP_LEN - 1) : state.bounce_position + 1'b1;
    end else begin
      bounce_step = (state.bounce_position == '0) ? '0 : state.bounce_position - 1'b1;
    end
  end

  // Position state update
  always_comb begin
    state_next = state;
    if (s1_go) begin
      if (s1_action == ACT_ADVANCE) begin
        unique case (motion_mode)
          MODE_DOTS: state_next.dot_offset  = next_pos(state.dot_offset);
          MODE_WAVE: state_next.wave_centre = next_pos(state.wave_centre);
          MODE_PINGPONG: begin
            state_next.bounce_position = bounce_step;
            if (bounce_step == POS_W'(STRIP_LEN - 1) || bounce_step == '0)
              state_next.bounce_forward = !state.bounce_forward;
          end
          MODE_FLOW: state_next.flow_position = next_pos(state.flow_position);
          default: ;
        endcase
      end else if (motion_mode == MODE_BLINK && in_strip) begin
        // Galois step per in-strip blink pixel
        state_next.random_shift = state.random_shift[0]
                                ? ((state.random_shift >> 1) ^ LFSR_TAPS)
                                : (state.random_shift >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.dot_offset      <= POS_W'(1);
      state.wave_centre     <= '0;
      state.bounce_position <= '0;
      state.bounce_forward  <= 1'b1;
      state.flow_position   <= '0;
      state.random_shift    <= LFSR_SEED;
    end else begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= s1_go && s1_action == ACT_PIXEL;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_action == ACT_PIXEL) begin
      rsp_color  <= color;
      rsp_bright <= LEVEL_TABLE[sat4(brightness_level)];
    end
  end

  assign rsp.valid            = rsp_valid;
  assign rsp.pixel_color      = rsp_color;
  assign rsp.strip_brightness = rsp_bright;

`ifndef NO_ASSERTIONS
  // A pixel beat leaving the input register always lands in the output register
  a_pixel_lands: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_action == ACT_PIXEL |=> rsp.valid)
    else $error("pixel beat lost");

  // Frame advance outside ping-pong leaves the bounce state alone
  a_bounce_kept: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_action == ACT_ADVANCE && motion_mode != MODE_PINGPONG
    |=> $stable(state.bounce_position) && $stable(state.bounce_forward))
    else $error("bounce state moved in another mode");

  // Dot, flow and ping-pong positions stay on the strip
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(state.bounce_position) < CMP_W'(STRIP_LEN)
    && CMP_W'(state.dot_offset) < CMP_W'(STRIP_LEN)
    && CMP_W'(state.flow_position) < CMP_W'(STRIP_LEN))
    else $error("position off the strip");

  // The blink generator never locks up
  a_lfsr_live: assert property (@(posedge clk) disable iff (rst)
    state.random_shift != '0)
    else $error("blink generator reached zero");
`endif

endmodule

// ----- test/led_strip_pattern_generator_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_strip_pattern_generator_test
// Self-checking bench for the LED strip pattern generator. A driver pushes
// pixel and frame-advance beats from a queue. A local model of the animation
// state predicts each pixel beat. A monitor checks every response beat
// against the oldest prediction. Configuration changes only while idle.
// ----------------------------------------------------------------------------
module led_strip_pattern_generator_test;
  import lspg_pkg::*;

  localparam int LEDS        = 144;
  localparam int DOTS        = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_GAP   = 4;

  typedef struct packed {
    logic       action;
    logic [7:0] led;
  } led_req_t;

  typedef struct packed {
    logic [23:0] colour;
    logic [7:0]  level;
  } pixel_beat_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                wr_en;
  logic [CFG_A_W-1:0]  wr_index;
  logic [CFG_W-1:0]    wr_data;

  lspg_req_if req_ch ();
  lspg_rsp_if rsp_ch ();

  led_strip_pattern_generator uut (
    .clk      (clk),
    .rst      (rst),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always #4 clk = ~clk;

  // Stimulus and scoreboard storage
  led_req_t    pending_q [$];
  pixel_beat_t pixel_q [$];
  led_req_t    next_req;
  pixel_beat_t seen_beat;
  int          beats_queued;
  int          beats_taken;
  int          mismatches;
  int          cycles;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Model of the animation state and registers
  logic [2:0]  cfg_mode;
  logic [2:0]  cfg_colour;
  logic [2:0]  cfg_level;
  logic [7:0]  dot_pos;
  logic [7:0]  wave_pos;
  logic [7:0]  bounce_pos;
  logic        bounce_fwd;
  logic [7:0]  flow_pos;
  logic [31:0] blink_lfsr;

  // Table indexes above four clamp to the last entry
  function automatic int table_slot(input logic [2:0] v);
    return (v > 3'd4) ? 4 : int'(v);
  endfunction

  function automatic logic [23:0] base_colour(input int c);
    case (c)
      0:       return 24'h200000;
      1:       return 24'h002000;
      2:       return 24'h000020;
      3:       return 24'h202000;
      default: return 24'h201010;
    endcase
  endfunction

  function automatic logic [23:0] dot_colour(input int k);
    case (k)
      0:       return 24'h200000;
      1:       return 24'h201000;
      2:       return 24'h202000;
      3:       return 24'h002000;
      4:       return 24'h002020;
      5:       return 24'h000020;
      6:       return 24'h100010;
      default: return 24'h200010;
    endcase
  endfunction

  function automatic logic [7:0] level_value(input int l);
    case (l)
      0:       return 8'd30;
      1:       return 8'd60;
      2:       return 8'd100;
      3:       return 8'd150;
      default: return 8'd255;
    endcase
  endfunction

  // Colour of one LED; blink mode clocks the LFSR once per in-strip pixel
  function automatic logic [23:0] colour_of(input logic [7:0] idx);
    int   c;
    int   d;
    logic fb;
    c = table_slot(cfg_colour);
    if (int'(idx) >= LEDS) return 24'h0;
    case (cfg_mode)
      MODE_DOTS: begin
        d = (int'(idx) + LEDS - int'(dot_pos)) % LEDS;
        return (d < DOTS) ? dot_colour(d) : base_colour(c);
      end
      MODE_BLINK: begin
        fb = blink_lfsr[0];
        blink_lfsr = blink_lfsr >> 1;
        if (fb) blink_lfsr = blink_lfsr ^ 32'h8020_0003;
        return fb ? base_colour(c) : 24'h0;
      end
      MODE_WAVE: begin
        d = int'(wave_pos) - int'(idx);
        if (d < 0) d = -d;
        return (d < LEDS / 4) ? base_colour(c) : 24'h0;
      end
      MODE_PINGPONG: begin
        return (idx == bounce_pos) ? base_colour(c) : 24'h0;
      end
      MODE_FLOW: begin
        d = (int'(idx) + int'(flow_pos)) % LEDS;
        if (d < LEDS / 3) return base_colour(c);
        if (d < (2 * LEDS) / 3) return base_colour((c + 1) % 5);
        return base_colour((c + 2) % 5);
      end
      default: return base_colour(c);
    endcase
  endfunction

  // Frame advance moves only the active mode's position
  task automatic advance_frame();
    int p;
    case (cfg_mode)
      MODE_DOTS: dot_pos = 8'((int'(dot_pos) + 1) % LEDS);
      MODE_WAVE: wave_pos = 8'((int'(wave_pos) + 1) % LEDS);
      MODE_PINGPONG: begin
        p = int'(bounce_pos);
        if (bounce_fwd) p = (p + 1 < LEDS) ? p + 1 : LEDS - 1;
        else p = (p > 0) ? p - 1 : 0;
        bounce_pos = 8'(p);
        if (p == LEDS - 1 || p == 0) bounce_fwd = ~bounce_fwd;
      end
      MODE_FLOW: flow_pos = 8'((int'(flow_pos) + 1) % LEDS);
      default: ;
    endcase
  endtask

  // Model one accepted request beat
  task automatic predict_beat(input logic action, input logic [7:0] idx);
    pixel_beat_t b;
    if (action == ACT_ADVANCE) begin
      advance_frame();
    end else begin
      b.colour = colour_of(idx);
      b.level  = level_value(table_slot(cfg_level));
      pixel_q.push_back(b);
    end
  endtask

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (mismatches < 10)
      $display("%0t: %s: expected %h, got %h", $realtime, what, exp_v, act_v);
    mismatches++;
  endtask

  // Request driver
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        predict_beat(req_ch.action, req_ch.led_index);
        beats_taken++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_req = pending_q.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.action    <= next_req.action;
          req_ch.led_index <= next_req.led;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pixel_q.size() == 0) begin
          note_mismatch("unexpected beat", 32'h0,
                        {rsp_ch.pixel_color, rsp_ch.strip_brightness});
        end else begin
          seen_beat = pixel_q.pop_front();
          if (rsp_ch.pixel_color !== seen_beat.colour)
            note_mismatch("pixel_color", 32'(seen_beat.colour), 32'(rsp_ch.pixel_color));
          if (rsp_ch.strip_brightness !== seen_beat.level)
            note_mismatch("strip_brightness", 32'(seen_beat.level),
                          32'(rsp_ch.strip_brightness));
        end
      end
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic queue_beat(input logic action, input logic [7:0] idx);
    led_req_t r;
    r.action = action;
    r.led    = idx;
    pending_q.push_back(r);
    beats_queued++;
  endtask

  task automatic queue_advances(input int n);
    for (int i = 0; i < n; i++) queue_beat(ACT_ADVANCE, 8'($urandom_range(0, 255)));
  endtask

  // Wait for every queued beat to be taken and answered, then let the pipe empty
  task automatic settle();
    while (beats_taken != beats_queued || pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [2:0] val);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic set_config(input logic [2:0] m, input logic [2:0] c, input logic [2:0] l);
    settle();
    write_reg(CFG_MOTION_MODE, m);
    write_reg(CFG_COLOR_INDEX, c);
    write_reg(CFG_BRIGHTNESS_LEVEL, l);
    cfg_mode   = m;
    cfg_colour = c;
    cfg_level  = l;
  endtask

  function automatic logic [7:0] pick_led();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 8'($urandom_range(0, LEDS - 1));
    if (r < 95) return 8'($urandom_range(LEDS, 255));
    if (r < 97) return 8'd0;
    if (r < 98) return 8'(LEDS - 1);
    if (r < 99) return 8'(LEDS);
    return 8'd255;
  endfunction

  initial begin
    logic [2:0] m;
    logic [2:0] c;
    logic [2:0] l;
    int         start;
    bit         moving;

    rst              = 1'b1;
    wr_en            = 1'b0;
    wr_index         = '0;
    wr_data          = '0;
    req_ch.valid     = 1'b0;
    req_ch.action    = ACT_PIXEL;
    req_ch.led_index = '0;
    rsp_ch.ready     = 1'b0;
    beats_queued     = 0;
    beats_taken      = 0;
    mismatches       = 0;
    cycles           = 0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    cfg_mode         = 3'd0;
    cfg_colour       = 3'd0;
    cfg_level        = 3'd0;
    dot_pos          = 8'd1;
    wave_pos         = 8'd0;
    bounce_pos       = 8'd0;
    bounce_fwd       = 1'b1;
    flow_pos         = 8'd0;
    blink_lfsr       = 32'h1234_5678;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, dots around the strip ends and beyond it
    queue_beat(ACT_PIXEL, 8'd0);
    queue_beat(ACT_PIXEL, 8'd1);
    queue_beat(ACT_PIXEL, 8'd8);
    queue_beat(ACT_PIXEL, 8'd9);
    queue_beat(ACT_PIXEL, 8'd143);
    queue_beat(ACT_PIXEL, 8'd144);
    queue_beat(ACT_PIXEL, 8'd255);
    queue_beat(ACT_ADVANCE, 8'd0);
    queue_beat(ACT_PIXEL, 8'd1);

    // Solid with colour and brightness clamped
    set_config(3'd7, 3'd7, 3'd7);
    queue_beat(ACT_PIXEL, 8'd0);
    queue_beat(ACT_PIXEL, 8'd200);

    // Blink; the off-strip pixel must not clock the generator
    set_config(MODE_BLINK, 3'd4, 3'd4);
    queue_beat(ACT_PIXEL, 8'd0);
    queue_beat(ACT_PIXEL, 8'd144);
    queue_beat(ACT_PIXEL, 8'd143);

    // Ping-pong first step
    set_config(MODE_PINGPONG, 3'd5, 3'd1);
    queue_beat(ACT_PIXEL, 8'd0);
    queue_beat(ACT_ADVANCE, 8'd255);
    queue_beat(ACT_PIXEL, 8'd1);

    // Wave band edge
    set_config(MODE_WAVE, 3'd1, 3'd2);
    queue_beat(ACT_PIXEL, 8'd35);
    queue_beat(ACT_PIXEL, 8'd36);

    // Flow thirds, palette wrapping past the last colour
    set_config(MODE_FLOW, 3'd3, 3'd3);
    queue_beat(ACT_PIXEL, 8'd47);
    queue_beat(ACT_PIXEL, 8'd48);
    queue_beat(ACT_PIXEL, 8'd96);

    set_config(3'd5, 3'd2, 3'd0);
    queue_beat(ACT_PIXEL, 8'd10);
    set_config(3'd6, 3'd6, 3'd5);
    queue_beat(ACT_PIXEL, 8'd10);

    // Random phases, one per mode code twice over, with changing idle profiles
    for (int k = 0; k < 16; k++) begin
      m = 3'(k % 8);
      c = (k == 0) ? 3'd0 : (k == 15) ? 3'd7 : (k == 1) ? 3'd4 : 3'($urandom_range(0, 7));
      l = (k == 0) ? 3'd0 : (k == 15) ? 3'd7 : (k == 1) ? 3'd4 : 3'($urandom_range(0, 7));
      set_config(m, c, l);
      case ((k + k / 8) % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      moving = (m == MODE_DOTS) || (m == MODE_WAVE) || (m == MODE_PINGPONG) ||
               (m == MODE_FLOW);

      // Long run so positions wrap and the ping-pong dot turns at the far end
      if (moving && k < 8) queue_advances($urandom_range(140, 200));

      for (int s = 0; s < (moving ? 12 : 30); s++) begin
        // Sender holds off until the pipe is empty
        if (k % 4 == 3 && s == 6) settle();
        if (moving && $urandom_range(0, 1) == 1) queue_advances($urandom_range(1, 6));
        else queue_beat(ACT_PIXEL, pick_led());
      end

      // Sweep of neighbouring LEDs, wrapping round the strip
      if (moving && k >= 8) begin
        start = $urandom_range(0, LEDS - 1);
        for (int j = 0; j < 48; j++) queue_beat(ACT_PIXEL, 8'((start + j) % LEDS));
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/lspg_pkg.sv
hdl/lspg_if.sv
hdl/lspg_pixel.sv
hdl/led_strip_pattern_generator.sv
test/led_strip_pattern_generator_test.sv
